// ===== hdl/omc_pkg.sv =====
package omc_pkg;

    localparam int IN_W           = 16;
    localparam int COST_W         = 40;
    localparam int MAX_ITEMS_DEF  = 1024;
    localparam int VALUE_BITS_DEF = 16;

    typedef struct packed {
        logic [COST_W-1:0] total_cost;
        logic              overflow;
    } res_t;

endpackage

// ===== hdl/omc_if.sv =====
interface omc_in_if;
    logic                     valid;
    logic                     ready;
    logic [omc_pkg::IN_W-1:0] value;
    logic                     last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface omc_out_if;
    logic                       valid;
    logic                       ready;
    logic [omc_pkg::COST_W-1:0] total_cost;
    logic                       overflow;

    modport source (output valid, output total_cost, output overflow, input ready);
    modport sink   (input valid, input total_cost, input overflow, output ready);
endinterface

// ===== hdl/omc_ram.sv =====
module omc_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/omc_engine.sv =====
module omc_engine #(
    parameter int MAX_ITEMS  = omc_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_BITS = omc_pkg::VALUE_BITS_DEF,
    parameter int AW         = $clog2(MAX_ITEMS),
    parameter int EW         = VALUE_BITS + $clog2(MAX_ITEMS) + 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [omc_pkg::IN_W-1:0] in_value,
    input  logic                     in_last,
    output logic                     res_valid,
    input  logic                     res_ready,
    output omc_pkg::res_t            res,
    output logic                     mem_we,
    output logic [AW-1:0]            mem_waddr,
    output logic [EW-1:0]            mem_wdata,
    output logic [AW-1:0]            mem_raddr,
    input  logic [EW-1:0]            mem_rdata
);

    import omc_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int XW = AW + 2;
    localparam logic [IN_W-1:0] VMASK =
        (VALUE_BITS >= IN_W) ? '1 : IN_W'((64'd1 << VALUE_BITS) - 64'd1);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_UP   = 12'b000000000010,
        S_UP_W = 12'b000000000100,
        S_MCHK = 12'b000000001000,
        S_POP0 = 12'b000000010000,
        S_POP1 = 12'b000000100000,
        S_POP2 = 12'b000001000000,
        S_DN   = 12'b000010000000,
        S_DN_L = 12'b000100000000,
        S_DN_R = 12'b001000000000,
        S_SUM  = 12'b010000000000,
        S_OUT  = 12'b100000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [EW-1:0]     v_reg, v_next;
    logic [EW-1:0]     a_reg, a_next;
    logic [EW-1:0]     b_reg, b_next;
    logic [EW-1:0]     hl_reg, hl_next;
    logic [COST_W-1:0] cost_reg, cost_next;
    logic              ovf_reg, ovf_next;
    logic              merging_reg, merging_next;
    logic              second_reg, second_next;

    logic [XW-1:0]     l_idx;
    logic [XW-1:0]     r_idx;
    logic [XW-1:0]     cnt_x;
    logic [AW-1:0]     parent;
    logic [EW-1:0]     sum;
    logic              left_lt;
    logic [EW-1:0]     best;
    logic              pop_done;
    logic              ins_done;

    assign l_idx   = {1'b0, pos_reg, 1'b1};
    assign r_idx   = l_idx + XW'(1);
    assign cnt_x   = XW'(cnt_reg);
    assign parent  = (pos_reg - AW'(1)) >> 1;
    assign sum     = a_reg + b_reg;
    assign left_lt = hl_reg < v_reg;
    assign best    = left_lt ? hl_reg : v_reg;

    assign res.total_cost = cost_reg;
    assign res.overflow   = ovf_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        v_next       = v_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        hl_next      = hl_reg;
        cost_next    = cost_reg;
        ovf_next     = ovf_reg;
        merging_next = merging_reg;
        second_next  = second_reg;
        mem_we       = 1'b0;
        mem_waddr    = pos_reg;
        mem_wdata    = v_reg;
        mem_raddr    = '0;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        pop_done     = 1'b0;
        ins_done     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (cnt_reg < CW'(MAX_ITEMS))
                    begin
                        v_next       = EW'(in_value & VMASK);
                        pos_next     = cnt_reg[AW-1:0];
                        cnt_next     = cnt_reg + CW'(1);
                        merging_next = in_last;
                        state_next   = S_UP;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                        if (in_last)
                        begin
                            merging_next = 1'b1;
                            state_next   = S_MCHK;
                        end
                    end
                end
            end
            S_UP:
            begin
                if (pos_reg == '0)
                begin
                    mem_we   = 1'b1;
                    ins_done = 1'b1;
                end
                else
                begin
                    mem_raddr  = parent;
                    state_next = S_UP_W;
                end
            end
            S_UP_W:
            begin
                mem_we = 1'b1;
                if (mem_rdata > v_reg)
                begin
                    mem_wdata  = mem_rdata;
                    pos_next   = parent;
                    state_next = S_UP;
                end
                else
                begin
                    ins_done = 1'b1;
                end
            end
            S_MCHK:
            begin
                if (cnt_reg > CW'(1))
                begin
                    second_next = 1'b0;
                    state_next  = S_POP0;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_POP0:
            begin
                mem_raddr  = '0;
                state_next = S_POP1;
            end
            S_POP1:
            begin
                if (second_reg)
                begin
                    b_next = mem_rdata;
                end
                else
                begin
                    a_next = mem_rdata;
                end
                cnt_next   = cnt_reg - CW'(1);
                mem_raddr  = AW'(cnt_reg - CW'(1));
                state_next = S_POP2;
            end
            S_POP2:
            begin
                v_next     = mem_rdata;
                pos_next   = '0;
                state_next = S_DN;
            end
            S_DN:
            begin
                if (l_idx >= cnt_x)
                begin
                    mem_we   = 1'b1;
                    pop_done = 1'b1;
                end
                else
                begin
                    mem_raddr  = l_idx[AW-1:0];
                    state_next = S_DN_L;
                end
            end
            S_DN_L:
            begin
                hl_next = mem_rdata;
                if (r_idx < cnt_x)
                begin
                    mem_raddr  = r_idx[AW-1:0];
                    state_next = S_DN_R;
                end
                else
                begin
                    mem_we = 1'b1;
                    if (mem_rdata < v_reg)
                    begin
                        mem_wdata  = mem_rdata;
                        pos_next   = l_idx[AW-1:0];
                        state_next = S_DN;
                    end
                    else
                    begin
                        pop_done = 1'b1;
                    end
                end
            end
            S_DN_R:
            begin
                mem_we = 1'b1;
                if (mem_rdata < best)
                begin
                    mem_wdata  = mem_rdata;
                    pos_next   = r_idx[AW-1:0];
                    state_next = S_DN;
                end
                else if (left_lt)
                begin
                    mem_wdata  = hl_reg;
                    pos_next   = l_idx[AW-1:0];
                    state_next = S_DN;
                end
                else
                begin
                    pop_done = 1'b1;
                end
            end
            S_SUM:
            begin
                v_next     = sum;
                cost_next  = cost_reg + COST_W'(sum);
                pos_next   = cnt_reg[AW-1:0];
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_UP;
            end
            S_OUT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    cnt_next     = '0;
                    cost_next    = '0;
                    ovf_next     = 1'b0;
                    merging_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ins_done)
        begin
            state_next = merging_reg ? S_MCHK : S_IDLE;
        end

        if (pop_done)
        begin
            if (second_reg)
            begin
                state_next = S_SUM;
            end
            else
            begin
                second_next = 1'b1;
                state_next  = S_POP0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            pos_reg     <= '0;
            cost_reg    <= '0;
            ovf_reg     <= 1'b0;
            merging_reg <= 1'b0;
            second_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
            cost_reg    <= cost_next;
            ovf_reg     <= ovf_next;
            merging_reg <= merging_next;
            second_reg  <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg  <= v_next;
        a_reg  <= a_next;
        b_reg  <= b_next;
        hl_reg <= hl_next;
    end

endmodule

// ===== hdl/optimal_merge_cost.sv =====
// Channel   Dir  Payload                       Moves when
// load      in   value[15:0], last             load.valid && load.ready
// result    out  total_cost[39:0], overflow    result.valid && result.ready
//
// Loading an item sifts it up the heap one level at a time through the
// single read port of the heap RAM. An item with last then merges: each
// step is two pops and one insert of their sum.
// Reset clears the control state only; heap RAM contents are not cleared.
// The result sits in an output register; a new set loads while it waits.
module optimal_merge_cost #(
    parameter int MAX_ITEMS  = omc_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_BITS = omc_pkg::VALUE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    omc_in_if.sink    load,
    omc_out_if.source result
);

    import omc_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int EW = VALUE_BITS + $clog2(MAX_ITEMS) + 1;

    logic          res_valid;
    logic          res_ready;
    res_t          res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;

    logic              out_valid_reg;
    logic [COST_W-1:0] out_cost_reg;
    logic              out_ovf_reg;

    omc_engine #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS),
        .AW         (AW),
        .EW         (EW)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (load.valid),
        .in_ready  (load.ready),
        .in_value  (load.value),
        .in_last   (load.last),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    omc_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_heap (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_cost_reg <= res.total_cost;
            out_ovf_reg  <= res.overflow;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.total_cost = out_cost_reg;
    assign result.overflow   = out_ovf_reg;

endmodule
